@@ src/ddo_pkg.sv @@
`timescale 1ns / 1ps
// Package for the differential-drive odometry block.
// Holds constants, register indexes, sequencer states and the CORDIC angle table.
package ddo_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TICK_BITS_DEF    = 16;
  localparam int MAX_STEPS        = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_MM_PER_TICK    = 2'd0,
    REG_ANGLE_PER_TICK = 2'd1,
    REG_GAIN_P         = 2'd2,
    REG_GAIN_I         = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_L, ST_MUL_R, ST_MUL_H, ST_CORDIC, ST_MUL_X, ST_MUL_Y,
    ST_PI_P, ST_PI_I, ST_DONE
  } state_t;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/ddo_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the odometry block.
// Depends on nothing; payload widths are fixed.
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] ticks_left;
  logic        [15:0] ticks_right;
  logic signed [15:0] drive_setpoint;
  modport source (output valid, ticks_left, ticks_right, drive_setpoint, input ready);
  modport sink   (input valid, ticks_left, ticks_right, drive_setpoint, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] adjust_right;
  logic signed [15:0] adjust_left;
  logic signed [47:0] pose_x;
  logic signed [47:0] pose_y;
  logic signed [15:0] heading_angle;
  logic        [47:0] distance_total;
  modport source (output valid, adjust_right, adjust_left, pose_x, pose_y,
                  heading_angle, distance_total, input ready);
  modport sink   (input valid, adjust_right, adjust_left, pose_x, pose_y,
                  heading_angle, distance_total, output ready);
endinterface

interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ddo_cordic.sv @@
`timescale 1ns / 1ps
// Iterative CORDIC in rotation mode, one micro-rotation per cycle.
// Depends on ddo_pkg for the arctangent table and gain.
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [31:0] angle,
  output logic               done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);
  import ddo_pkg::*;

  localparam int SW = $clog2(STEPS + 1);

  logic signed [33:0] x, y, z;
  logic               flip, busy;
  logic [SW-1:0]      step;
  logic [31:0]        ang_rot;
  logic signed [33:0] dx, dy, at;
  logic [4:0]         shamt;

  assign ang_rot = (angle[31] ^ angle[30]) ? angle + 32'h8000_0000 : angle;
  assign shamt   = 5'(step);
  assign dx      = y >>> shamt;
  assign dy      = x >>> shamt;
  assign at      = atan_lut(shamt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= 34'(signed'(ang_rot));
        flip <= angle[31] ^ angle[30];
      end else if (busy) begin
        if (step == SW'(STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          // rotate toward zero residual angle
          if (!z[33]) begin
            x <= x - dx; y <= y + dy; z <= z - at;
          end else begin
            x <= x + dx; y <= y - dy; z <= z + at;
          end
          step <= step + 1'b1;
        end
      end
    end
  end

  assign cos_q30 = flip ? -x : x;
  assign sin_q30 = flip ? -y : y;
endmodule

@@ src/ddo_mul.sv @@
`timescale 1ns / 1ps
// Shared registered signed multiplier, 42 x 26 bits, one product per cycle.
// Depends on nothing.
module ddo_mul (
  input  logic               clk,
  input  logic signed [41:0] a,
  input  logic signed [25:0] b,
  output logic signed [67:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

@@ src/diff_drive_odometry_heading_pi.sv @@
`timescale 1ns / 1ps
// Differential-drive odometry with PI heading control. Each request with a
// positive drive setpoint scales the wheel ticks to travel, advances X/Y by the
// center travel times cos/sin of the old heading (iterative CORDIC), adds to the
// saturating distance, moves the 32-bit binary heading, and runs a saturating PI
// on the wrapped heading; a request with setpoint <= 0 is taken without leaving
// idle and gives no result. The CORDIC iterations, started when a request is
// taken, set the length of an update: the wheel and heading-step multiplies
// run beside them, and afterwards the one shared multiplier serves both
// position steps and both PI products in turn. The block takes no request while
// it works; a finished result waits in the output register, and a following
// update holds in its last state until that result is taken. Config writes are
// always accepted; change registers only while idle.
module diff_drive_odometry_heading_pi #(
  parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int TICK_BITS    = ddo_pkg::TICK_BITS_DEF
) (
  input logic clk,
  input logic rst,
  ddo_in_if.sink    in_ch,
  ddo_out_if.source out_ch,
  ddo_cfg_if.sink   cfg
);
  import ddo_pkg::*;

  localparam logic [47:0] MAX48 = '1;
  localparam logic [15:0] TMASK = 16'((64'd1 << TICK_BITS) - 64'd1);

  state_t state, state_next;

  logic [23:0]        mm_per_tick, angle_per_tick;
  logic signed [15:0] gain_p, gain_i;
  logic signed [47:0] pos_x, pos_y;
  logic [31:0]        heading;
  logic [47:0]        travelled;
  logic signed [31:0] integral;

  logic [15:0]          tl, tr;
  logic [47:0]          dl, centre;
  logic [31:0]          dth;
  logic signed [33:0]   c16, s16;
  logic signed [31:0]   err;
  logic signed [47:0]   pterm;
  logic                 mul_wait;

  logic signed [41:0] ma;
  logic signed [25:0] mb;
  logic signed [67:0] mp;
  logic signed [16:0] dtick;
  logic               cstart, cdone;
  logic signed [33:0] c30, s30;

  logic               out_valid;
  logic signed [15:0] w;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_tick <= '0; angle_per_tick <= '0; gain_p <= '0; gain_i <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_MM_PER_TICK:    mm_per_tick    <= cfg.data;
        REG_ANGLE_PER_TICK: angle_per_tick <= cfg.data;
        REG_GAIN_P:         gain_p         <= cfg.data[15:0];
        REG_GAIN_I:         gain_i         <= cfg.data[15:0];
      endcase
    end
  end

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start(cstart), .angle(heading), .done(cdone),
    .cos_q30(c30), .sin_q30(s30)
  );

  ddo_mul u_mul (.clk, .a(ma), .b(mb), .p(mp));

  // signed tick difference drives the heading step
  assign dtick = signed'({1'b0, tr}) - signed'({1'b0, tl});

  // operand select for the shared multiplier
  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      ST_MUL_L: begin ma = 42'(mm_per_tick); mb = 26'(tl); end
      ST_MUL_R: begin ma = 42'(mm_per_tick); mb = 26'(tr); end
      ST_MUL_H: begin ma = 42'(dtick); mb = 26'(angle_per_tick); end
      ST_MUL_X: begin ma = 42'(centre[39:0]); mb = 26'(c16); end
      ST_MUL_Y: begin ma = 42'(centre[39:0]); mb = 26'(s16); end
      ST_PI_P:  begin ma = 42'(err); mb = 26'(gain_p); end
      ST_PI_I:  begin ma = 42'(integral); mb = 26'(gain_i); end
      default: ;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign cstart      = (state == ST_IDLE) && in_ch.valid && (in_ch.drive_setpoint > 0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (cstart) state_next = ST_MUL_L;
      ST_MUL_L:  if (mul_wait) state_next = ST_MUL_R;
      ST_MUL_R:  if (mul_wait) state_next = ST_MUL_H;
      ST_MUL_H:  if (mul_wait) state_next = ST_CORDIC;
      ST_CORDIC: if (cdone) state_next = ST_MUL_X;
      ST_MUL_X:  if (mul_wait) state_next = ST_MUL_Y;
      ST_MUL_Y:  if (mul_wait) state_next = ST_PI_P;
      ST_PI_P:   if (mul_wait) state_next = ST_PI_I;
      ST_PI_I:   if (mul_wait) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath; each multiply state issues its operands, then collects the registered product
  logic signed [48:0] isum;
  logic signed [49:0] wsum;
  logic [48:0]        tsum;
  logic [31:0]        hnew;
  always_comb begin
    isum = 49'(integral) + 49'(err);
    wsum = 50'(pterm) + 50'(signed'(mp[47:0]));
    tsum = {1'b0, travelled} + {1'b0, centre};
    hnew = heading + dth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_wait <= 1'b0;
      pos_x <= '0; pos_y <= '0; heading <= '0; travelled <= '0; integral <= '0;
    end else begin
      mul_wait <= 1'b0;
      if (state == ST_MUL_L || state == ST_MUL_R || state == ST_MUL_H ||
          state == ST_MUL_X || state == ST_MUL_Y || state == ST_PI_P ||
          state == ST_PI_I)
        mul_wait <= !mul_wait;
      unique case (state)
        ST_IDLE: if (cstart) begin
          tl <= in_ch.ticks_left & TMASK;
          tr <= in_ch.ticks_right & TMASK;
        end
        ST_MUL_L: if (mul_wait) dl <= mp[47:0];
        ST_MUL_R: if (mul_wait) centre <= 48'((49'(dl) + 49'(mp[47:0])) >> 1);
        ST_MUL_H: if (mul_wait) dth <= mp[31:0];
        ST_CORDIC: if (cdone) begin
          c16 <= c30 >>> 14;
          s16 <= s30 >>> 14;
          travelled <= tsum[48] ? MAX48 : tsum[47:0];
          heading <= hnew;
          err <= 32'(signed'(hnew[31 -: ANGLE_BITS]));
        end
        ST_MUL_X: if (mul_wait) pos_x <= pos_x + 48'(mp >>> 16);
        ST_MUL_Y: if (mul_wait) begin
          pos_y <= pos_y + 48'(mp >>> 16);
          if (isum > 49'sd2147483647)       integral <= 32'sh7fffffff;
          else if (isum < -49'sd2147483648) integral <= 32'sh80000000;
          else                              integral <= isum[31:0];
        end
        ST_PI_P: if (mul_wait) pterm <= mp[47:0];
        ST_PI_I: if (mul_wait) begin
          if ((wsum >>> 8) > 50'sd32767)       w <= 16'sh7fff;
          else if ((wsum >>> 8) < -50'sd32768) w <= 16'sh8000;
          else                                 w <= wsum[23:8];
        end
        default: ;
      endcase
    end
  end

  // output register; hold until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_DONE && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
      out_ch.adjust_right   <= w;
      out_ch.adjust_left    <= (w == 16'sh8000) ? 16'sh7fff : -w;
      out_ch.pose_x         <= pos_x;
      out_ch.pose_y         <= pos_y;
      out_ch.heading_angle  <= heading[31:16];
      out_ch.distance_total <= travelled;
    end
  end
  assign out_ch.valid = out_valid;
endmodule

@@ src/ddo_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the odometry block, bound to the top level.
// Depends on nothing but the top-level port signals.
module ddo_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] setpoint,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] adj_r,
  input logic signed [15:0] adj_l
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(adj_r))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && setpoint > 0 |=> !in_ready)
    else $error("new request taken during update");
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && setpoint <= 0 && !out_valid |=> !out_valid)
    else $error("result for idle setpoint");
  a_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (adj_r == 16'sh8000 ? adj_l == 16'sh7fff : adj_l == -adj_r))
    else $error("left correction not negated right");
endmodule

bind diff_drive_odometry_heading_pi ddo_port_checks u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .setpoint(in_ch.drive_setpoint), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .adj_r(out_ch.adjust_right), .adj_l(out_ch.adjust_left)
);
